/* rtl/core/rfd_pkg.sv */
package rfd_pkg;

	// frame length field width; the count saturates at all ones
	localparam int LENGTH_BITS     = 16;
	localparam int MIN_FRAME_WORDS = 4;

	localparam logic [7:0]  START_MARK   = 8'hA5;
	localparam logic [7:0]  SKIP_CHANNEL = 8'hFF;
	localparam logic [63:0] NS_PER_S     = 64'd1000000000;
	localparam logic [29:0] NS_PER_S_30  = 30'd1000000000;
	// the seconds window (1e9, 3e9) lies wholly below this, so only this test decides
	localparam logic [63:0] NS_THRESHOLD = 64'd1000000000000;

	// 1e9 = 2^9 * 5^9: shift out the power of two, then divide by 5^9 through a
	// reciprocal exact for every 55-bit dividend (shift 55 + 21)
	localparam int unsigned DIV_SHIFT   = 9;
	localparam logic [76:0] DIV_ODD     = 77'd1953125;
	localparam int unsigned RECIP_SHIFT = 76;
	localparam logic [76:0] RECIP_FULL  =
		((77'd1 << RECIP_SHIFT) + DIV_ODD - 77'd1) / DIV_ODD;
	localparam logic [55:0] RECIP       = RECIP_FULL[55:0];

	typedef struct packed {
		logic [31:0] data_word;
		logic        end_of_stream;
	} word_t;

	typedef struct packed {
		logic [7:0]             hdr_version;
		logic [7:0]             subsys_id;
		logic [7:0]             contributor_id;
		logic [63:0]            time_ns;
		logic [LENGTH_BITS-1:0] length_words;
	} desc_t;

	// closed frame waiting for the timestamp path
	typedef struct packed {
		logic [23:0]            first_word;
		logic [63:0]            stamp;
		logic [LENGTH_BITS-1:0] length;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/core/readout_frame_header_deframer.sv */
// Readout frame deframer. Takes one 32-bit word per cycle on the word channel
// while word_stall is low; a frame opens at any word whose top byte is 0xA5 and
// closes at the next start word or at the word flagged end_of_stream. A frame
// of at least four words whose second word's top byte is not 0xFF yields one
// descriptor: the three header bytes of word 0, the frame length (saturating)
// and a timestamp in ns built from words 2 and 3 (low word first). Stamps above
// 1e12 are read as ns and cut to whole seconds before scaling back by 1e9; all
// others are taken as seconds. A closed frame goes through the descriptor queue
// and the back-end stages s1 to s7, the last being the output register; the
// back end delivers one descriptor per cycle while the descriptor channel is
// not held. The word channel stalls only while the descriptor queue
// (QUEUE_DEPTH entries) is full, which happens only when the channel is held.
module readout_frame_header_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            word_valid,
	output logic            word_stall,
	input  rfd_pkg::word_t  word,
	output logic            desc_valid,
	input  logic            desc_stall,
	output rfd_pkg::desc_t  desc
);
	import rfd_pkg::*;

	// front -> queue
	logic      push;
	frame_t    push_frame;
	// queue -> back
	logic      pop;
	frame_t    head;
	q_status_t q_status;

	// front: tracks the open frame, captures header and stamp words,
	// decides at close whether a descriptor is due
	rfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.q_status   (q_status),
		.push       (push),
		.push_frame (push_frame)
	);

	// closed frames waiting for the timestamp pipe
	rfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back: seven-stage pipe, divide by 1e9 through the reciprocal, scale to ns,
	// last stage is the descriptor output register
	rfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.desc       (desc)
	);

endmodule

/* rtl/core/rfd_front.sv */
module rfd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              word_valid,
	output logic              word_stall,
	input  rfd_pkg::word_t    word,
	input  rfd_pkg::q_status_t q_status,
	output logic              push,
	output rfd_pkg::frame_t   push_frame
);
	import rfd_pkg::*;

	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] COUNT_MIN = LENGTH_BITS'(MIN_FRAME_WORDS);

	logic                   open_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic [23:0]            first_q;
	logic [7:0]             chan_q;
	logic [31:0]            lo_q, hi_q;

	logic                   accept, start, eos;
	logic                   ok_prev, ok_cur;
	logic [LENGTH_BITS-1:0] count_t;
	logic [23:0]            first_t;
	logic [7:0]             chan_t;
	logic [31:0]            lo_t, hi_t;

	assign word_stall = q_status.full;
	assign accept     = word_valid && !q_status.full;
	assign start      = (word.data_word[31:24] == START_MARK);
	assign eos        = word.end_of_stream;

	// open frame with the current word taken in
	always_comb begin
		first_t = first_q;
		chan_t  = chan_q;
		lo_t    = lo_q;
		hi_t    = hi_q;
		if (count_q == LENGTH_BITS'(0)) begin
			first_t = word.data_word[23:0];
		end else if (count_q == LENGTH_BITS'(1)) begin
			chan_t = word.data_word[31:24];
		end else if (count_q == LENGTH_BITS'(2)) begin
			lo_t = word.data_word;
		end else if (count_q == LENGTH_BITS'(3)) begin
			hi_t = word.data_word;
		end
		count_t = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	end

	assign ok_prev = (count_q >= COUNT_MIN) && (chan_q != SKIP_CHANNEL);
	assign ok_cur  = (count_t >= COUNT_MIN) && (chan_t != SKIP_CHANNEL);

	// a start word closes the frame before it; otherwise end of stream closes
	// the frame including this word
	assign push = accept && open_q && (start ? ok_prev : (eos && ok_cur));

	always_comb begin
		if (start) begin
			push_frame.first_word = first_q;
			push_frame.stamp      = {hi_q, lo_q};
			push_frame.length     = count_q;
		end else begin
			push_frame.first_word = first_t;
			push_frame.stamp      = {hi_t, lo_t};
			push_frame.length     = count_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			priority if (eos) begin
				open_q  <= 1'b0;
				count_q <= '0;
			end else if (start) begin
				open_q  <= 1'b1;
				count_q <= LENGTH_BITS'(1);
			end else if (open_q) begin
				count_q <= count_t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (start) begin
				first_q <= word.data_word[23:0];
			end else if (open_q) begin
				first_q <= first_t;
				chan_q  <= chan_t;
				lo_q    <= lo_t;
				hi_q    <= hi_t;
			end
		end
	end

	a_push_long: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_frame.length >= COUNT_MIN))
		else $error("frame queued with too few words");

	a_eos_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eos) |=> (!open_q && count_q == '0))
		else $error("frame still open after end of stream");

endmodule

/* rtl/core/rfd_queue.sv */
module rfd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rfd_pkg::frame_t    push_frame,
	input  logic               pop,
	output rfd_pkg::frame_t    head,
	output rfd_pkg::q_status_t status
);
	import rfd_pkg::*;

	// DEPTH of two or more
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	frame_t           entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] fill_q;

	assign status.full  = (fill_q == CNT_W'(DEPTH));
	assign status.empty = (fill_q == '0);
	assign head         = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_frame;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");

endmodule

/* rtl/core/rfd_back.sv */
module rfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rfd_pkg::q_status_t q_status,
	input  rfd_pkg::frame_t    head,
	output logic               pop,
	output logic               desc_valid,
	input  logic               desc_stall,
	output rfd_pkg::desc_t     desc
);
	import rfd_pkg::*;

	localparam int X_W = 64 - DIV_SHIFT;

	logic en;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [23:0]            hdr_s1, hdr_s2, hdr_s3, hdr_s4, hdr_s5, hdr_s6;
	logic [LENGTH_BITS-1:0] len_s1, len_s2, len_s3, len_s4, len_s5, len_s6;
	logic [63:0]            raw_s1, raw_s2, raw_s3, raw_s4;
	logic                   big_s1, big_s2, big_s3, big_s4;
	logic [X_W-1:0]         x_s2, x_s3, x_s4;
	logic [31:0]            acc_s2;
	logic [56:0]            acc_s3;
	logic [57:0]            acc_s4;
	logic [63:0]            sec_s5;
	logic [61:0]            m0_s6;
	logic [31:0]            sec_hi_s6;
	desc_t                  desc_s7;

	logic [X_W-1:0] x_s1;
	logic [63:0]    p0;
	logic [55:0]    p1;
	logic [57:0]    p2;
	logic [46:0]    p3;
	logic [78:0]    a4;
	logic [34:0]    quot;
	logic [61:0]    m0;
	logic [31:0]    m1;

	// whole pipe moves together unless the finished item is held
	assign en  = !(v_s7 && desc_stall);
	assign pop = en && !q_status.empty;

	// quotient by 1e9: partial products of the reciprocal, one per stage
	assign x_s1 = raw_s1[63:DIV_SHIFT];
	assign p0   = 64'(x_s1[31:0]) * 64'(RECIP[31:0]);
	assign p1   = 56'(x_s2[31:0]) * 56'(RECIP[55:32]);
	assign p2   = 58'(x_s3[X_W-1:32]) * 58'(RECIP[31:0]);
	assign p3   = 47'(x_s4[X_W-1:32]) * 47'(RECIP[55:32]);
	assign a4   = 79'(acc_s4) + {p3, 32'b0};
	assign quot = a4[78:RECIP_SHIFT-32];

	// seconds to ns, modulo 2^64: low half full, high half only its low word
	assign m0 = 62'(sec_s5[31:0]) * 62'(NS_PER_S_30);
	assign m1 = sec_hi_s6 * 32'(NS_PER_S_30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_status.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s1 <= head.first_word;
			len_s1 <= head.length;
			raw_s1 <= head.stamp;
			big_s1 <= (head.stamp > NS_THRESHOLD);

			hdr_s2 <= hdr_s1;
			len_s2 <= len_s1;
			raw_s2 <= raw_s1;
			big_s2 <= big_s1;
			x_s2   <= x_s1;
			acc_s2 <= p0[63:32];

			hdr_s3 <= hdr_s2;
			len_s3 <= len_s2;
			raw_s3 <= raw_s2;
			big_s3 <= big_s2;
			x_s3   <= x_s2;
			acc_s3 <= 57'(acc_s2) + 57'(p1);

			hdr_s4 <= hdr_s3;
			len_s4 <= len_s3;
			raw_s4 <= raw_s3;
			big_s4 <= big_s3;
			x_s4   <= x_s3;
			acc_s4 <= 58'(acc_s3) + p2;

			hdr_s5 <= hdr_s4;
			len_s5 <= len_s4;
			sec_s5 <= big_s4 ? 64'(quot) : raw_s4;

			hdr_s6    <= hdr_s5;
			len_s6    <= len_s5;
			m0_s6     <= m0;
			sec_hi_s6 <= sec_s5[63:32];

			desc_s7.hdr_version    <= hdr_s6[7:0];
			desc_s7.subsys_id      <= hdr_s6[15:8];
			desc_s7.contributor_id <= hdr_s6[23:16];
			desc_s7.time_ns        <= 64'(m0_s6) + {m1, 32'b0};
			desc_s7.length_words   <= len_s6;
		end
	end

	assign desc_valid = v_s7;
	assign desc       = desc_s7;

	a_quot_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && big_s4) |->
		((64'(quot) * NS_PER_S <= raw_s4) && (raw_s4 - 64'(quot) * NS_PER_S < NS_PER_S)))
		else $error("reciprocal quotient off by one");

endmodule
